// ===== hw/rtl/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape language interpreter package
// Shared index width, item kinds, command characters, sequencer states and the
// operation code of the shared increment and decrement unit.
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int IDX_W = 13;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_EXEC    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [7:0] CMD_RIGHT = 8'h3E;
   localparam logic [7:0] CMD_LEFT  = 8'h3C;
   localparam logic [7:0] CMD_INC   = 8'h2B;
   localparam logic [7:0] CMD_DEC   = 8'h2D;
   localparam logic [7:0] CMD_OUT   = 8'h2E;
   localparam logic [7:0] CMD_IN    = 8'h2C;
   localparam logic [7:0] CMD_OPEN  = 8'h5B;
   localparam logic [7:0] CMD_CLOSE = 8'h5D;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ADVANCE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_STEP
   } state_type;

   typedef struct packed {
      logic dec;
      logic wrap;
   } alu_op_type;

endpackage

// ===== hw/rtl/tli_ram.sv =====
// ----------------------------------------------------------------------------
// Tape language interpreter RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tli_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tli_alu.sv =====
// ----------------------------------------------------------------------------
// Tape language interpreter arithmetic unit
// Shared incrementer and decrementer with optional wrap at a fixed limit.
// ----------------------------------------------------------------------------
module tli_alu
   import tli_pkg::*;
#(
   parameter int W     = 16,
   parameter int LIMIT = 0
) (
   input  logic [W-1:0] a,
   input  alu_op_type   op,
   output logic [W-1:0] y,
   output logic         at_end
);

   localparam logic [W-1:0] LIM = W'(LIMIT);

   always_comb begin
      at_end = op.dec ? (a == '0) : (a == LIM);
      if (op.wrap && at_end) begin
         y = op.dec ? LIM : '0;
      end else begin
         y = op.dec ? (a - W'(1)) : (a + W'(1));
      end
   end

endmodule

// ===== hw/rtl/tape_language_interpreter_step.sv =====
// ----------------------------------------------------------------------------
// Tape language interpreter step
// Runs one instruction of the eight-command tape language per execute beat,
// loads program bytes and restarts the machine.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result appears on
// the rsp_ ports for exactly one cycle with rsp_valid high and cannot be held
// off. A load, an unused kind or an execute beat on a halted machine gives its
// result in the cycle after the beat.
// An execute beat for output, input, skipped bytes and brackets that do not
// jump passes only through DECODE; cell moves and cell arithmetic go through
// DECODE and ADVANCE. A bracket jump goes through SCAN_RD, SCAN_CHK and, on a
// bracket, SCAN_STEP for each program byte it scans and ends in ADVANCE on
// the match. This is set by the single shared increment and decrement unit
// and the registered read of the program and tape memories. After reset and
// on every restart beat the tape is cleared one cell per cycle with busy high;
// a restart gives its result when that pass is finished.
module tape_language_interpreter_step
   import tli_pkg::*;
#(
   parameter int TAPE_CELLS = 30000,
   parameter int PROG_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_kind,
   input  logic [11:0]      req_prog_addr,
   input  logic [7:0]       req_prog_byte,
   input  logic [7:0]       req_in_byte,
   output logic             rsp_valid,
   output logic             rsp_out_valid,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_in_taken,
   output logic             rsp_halted,
   output logic             rsp_bracket_error,
   output logic [IDX_W-1:0] rsp_next_index,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_program_length
);

   localparam int CW    = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
   localparam int PW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
   localparam int ALU_W = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [16:0] DEPTH_CAP = 17'(PROG_DEPTH);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] ip_ff, ip_in;
   logic [CW-1:0]    cidx_ff, cidx_in;
   logic             err_ff, err_in;
   logic [IDX_W-1:0] q_ff, q_in;
   logic [IDX_W-1:0] depth_ff, depth_in;
   logic             fwd_ff, fwd_in;
   logic [7:0]       inb_ff, inb_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             ov_ff, ov_in;
   logic [7:0]       ob_ff, ob_in;
   logic             took_ff, took_in;
   logic [IDX_W-1:0] plen_ff;

   logic             accept;
   logic [IDX_W-1:0] eff_len;
   logic             halted_now;
   logic [7:0]       op;
   logic [7:0]       cell_rd;
   logic             cell_zero;
   logic             scan_match;
   logic             scan_nest;
   logic             q_first;
   logic             q_beyond;

   logic [ALU_W-1:0] alu_a;
   logic [ALU_W-1:0] alu_y;
   alu_op_type       alu_op;
   logic             alu_at_end;

   logic             prog_we;
   logic [PW-1:0]    prog_raddr;
   logic             tape_we;
   logic [7:0]       tape_wdata;

   tli_ram #(
      .DEPTH(PROG_DEPTH),
      .WIDTH(8)
   ) u_prog (
      .clock(clock),
      .we   (prog_we),
      .waddr(PW'(req_prog_addr)),
      .wdata(req_prog_byte),
      .raddr(prog_raddr),
      .rdata(op)
   );

   tli_ram #(
      .DEPTH(TAPE_CELLS),
      .WIDTH(8)
   ) u_tape (
      .clock(clock),
      .we   (tape_we),
      .waddr(cidx_ff),
      .wdata(tape_wdata),
      .raddr(cidx_ff),
      .rdata(cell_rd)
   );

   tli_alu #(
      .W    (ALU_W),
      .LIMIT(TAPE_CELLS - 1)
   ) u_alu (
      .a     (alu_a),
      .op    (alu_op),
      .y     (alu_y),
      .at_end(alu_at_end)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign eff_len    = ({4'b0, plen_ff} < DEPTH_CAP) ? plen_ff : IDX_W'(PROG_DEPTH);
   assign halted_now = err_ff || (ip_ff >= eff_len);
   assign cell_zero  = (cell_rd == 8'd0);
   assign scan_match = fwd_ff ? (op == CMD_CLOSE) : (op == CMD_OPEN);
   assign scan_nest  = fwd_ff ? (op == CMD_OPEN) : (op == CMD_CLOSE);
   assign q_first    = !fwd_ff && (q_ff == '0);
   assign q_beyond   = fwd_ff && (q_ff >= eff_len);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (alu_at_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_EXEC && !halted_now) begin
                  state_in = ST_DECODE;
               end else if (req_kind == KIND_RESTART) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_DECODE: begin
            case (op)
               CMD_RIGHT, CMD_LEFT, CMD_INC, CMD_DEC: state_in = ST_ADVANCE;
               CMD_OPEN: state_in = cell_zero ? ST_SCAN_RD : ST_IDLE;
               CMD_CLOSE: begin
                  state_in = (!cell_zero && ip_ff != '0) ? ST_SCAN_RD : ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ADVANCE: state_in = ST_IDLE;
         ST_SCAN_RD: state_in = q_beyond ? ST_IDLE : ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (scan_match && depth_ff == '0) begin
               state_in = ST_ADVANCE;
            end else if (scan_match || scan_nest) begin
               state_in = ST_SCAN_STEP;
            end else if (q_first) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_STEP: state_in = q_first ? ST_IDLE : ST_SCAN_RD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ip_in        = ip_ff;
      cidx_in      = cidx_ff;
      err_in       = err_ff;
      q_in         = q_ff;
      depth_in     = depth_ff;
      fwd_in       = fwd_ff;
      inb_in       = inb_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      ov_in        = 1'b0;
      ob_in        = 8'd0;
      took_in      = 1'b0;
      alu_a        = '0;
      alu_op       = '{dec: 1'b0, wrap: 1'b0};
      prog_we      = 1'b0;
      prog_raddr   = PW'(q_ff);
      tape_we      = 1'b0;
      tape_wdata   = 8'd0;
      case (state_ff)
         ST_CLEAR: begin
            tape_we = 1'b1;
            alu_a   = ALU_W'(cidx_ff);
            alu_op  = '{dec: 1'b0, wrap: 1'b1};
            cidx_in = CW'(alu_y);
            if (alu_at_end) begin
               clr_rsp_in   = 1'b0;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         ST_IDLE: begin
            prog_raddr = PW'(ip_ff);
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     prog_we      = (int'(req_prog_addr) < PROG_DEPTH);
                     rsp_valid_in = 1'b1;
                  end
                  KIND_EXEC: begin
                     inb_in       = req_in_byte;
                     rsp_valid_in = halted_now;
                  end
                  KIND_RESTART: begin
                     ip_in      = '0;
                     err_in     = 1'b0;
                     cidx_in    = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_DECODE: begin
            alu_a = ALU_W'(ip_ff);
            ip_in = IDX_W'(alu_y);
            case (op)
               CMD_RIGHT, CMD_LEFT: begin
                  alu_a   = ALU_W'(cidx_ff);
                  alu_op  = '{dec: (op == CMD_LEFT), wrap: 1'b1};
                  ip_in   = ip_ff;
                  cidx_in = CW'(alu_y);
               end
               CMD_INC, CMD_DEC: begin
                  alu_a      = ALU_W'(cell_rd);
                  alu_op     = '{dec: (op == CMD_DEC), wrap: 1'b0};
                  ip_in      = ip_ff;
                  tape_we    = 1'b1;
                  tape_wdata = 8'(alu_y);
               end
               CMD_OUT: begin
                  ov_in        = 1'b1;
                  ob_in        = cell_rd;
                  rsp_valid_in = 1'b1;
               end
               CMD_IN: begin
                  tape_we      = 1'b1;
                  tape_wdata   = inb_ff;
                  took_in      = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               CMD_OPEN: begin
                  if (cell_zero) begin
                     ip_in    = ip_ff;
                     q_in     = IDX_W'(alu_y);
                     depth_in = '0;
                     fwd_in   = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               CMD_CLOSE: begin
                  if (cell_zero) begin
                     rsp_valid_in = 1'b1;
                  end else if (ip_ff == '0) begin
                     ip_in        = ip_ff;
                     err_in       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     alu_op   = '{dec: 1'b1, wrap: 1'b0};
                     ip_in    = ip_ff;
                     q_in     = IDX_W'(alu_y);
                     depth_in = '0;
                     fwd_in   = 1'b0;
                  end
               end
               default: rsp_valid_in = 1'b1;
            endcase
         end
         ST_ADVANCE: begin
            alu_a        = ALU_W'(ip_ff);
            ip_in        = IDX_W'(alu_y);
            rsp_valid_in = 1'b1;
         end
         ST_SCAN_RD: begin
            if (q_beyond) begin
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         ST_SCAN_CHK: begin
            if (scan_match && depth_ff == '0) begin
               ip_in = q_ff;
            end else if (scan_match || scan_nest) begin
               alu_a    = ALU_W'(depth_ff);
               alu_op   = '{dec: scan_match, wrap: 1'b0};
               depth_in = IDX_W'(alu_y);
            end else if (q_first) begin
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               alu_a  = ALU_W'(q_ff);
               alu_op = '{dec: !fwd_ff, wrap: 1'b0};
               q_in   = IDX_W'(alu_y);
            end
         end
         ST_SCAN_STEP: begin
            if (q_first) begin
               err_in       = 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               alu_a  = ALU_W'(q_ff);
               alu_op = '{dec: !fwd_ff, wrap: 1'b0};
               q_in   = IDX_W'(alu_y);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ip_ff        <= '0;
         cidx_ff      <= '0;
         err_ff       <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ip_ff        <= ip_in;
         cidx_ff      <= cidx_in;
         err_ff       <= err_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            plen_ff <= csr_program_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      depth_ff <= depth_in;
      fwd_ff   <= fwd_in;
      inb_ff   <= inb_in;
      ov_ff    <= ov_in;
      ob_ff    <= ob_in;
      took_ff  <= took_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_valid     = ov_ff;
   assign rsp_out_byte      = ob_ff;
   assign rsp_in_taken      = took_ff;
   assign rsp_halted        = halted_now;
   assign rsp_bracket_error = err_ff;
   assign rsp_next_index    = ip_ff;

   a_rsp_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(state_ff != ST_IDLE)))
      else $error("Result strobe without a beat in progress.");

   a_cell_in_range: assert property (@(posedge clock) disable iff (reset)
      cidx_ff <= CW'(TAPE_CELLS - 1))
      else $error("Cell index beyond the tape.");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff && !(accept && req_kind == KIND_RESTART)) |=> err_ff)
      else $error("Bracket error cleared without a restart.");

   a_one_io: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(ov_ff && took_ff))
      else $error("Output and input reported for the same beat.");

endmodule
